// ===== rtl/core/rsi_pkg.sv =====
// ----------------------------------------------------------------------------
// rsi_pkg
// Shared types, constants and helper functions of the ray/sphere intersect
// core.
// ----------------------------------------------------------------------------
package rsi_pkg;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CENTER_X = 3'd0,
		CFG_CENTER_Y = 3'd1,
		CFG_CENTER_Z = 3'd2,
		CFG_RADIUS   = 3'd3
	} cfg_reg_t;

	// normalizer: largest magnitude is aligned so its top bit lands here
	localparam int NORM_TOP = 29;
	localparam int NORM_W   = NORM_TOP + 1;
	localparam int MAG_W    = 33;
	localparam int LEAD_W   = 6;
	localparam int NSQ_W    = 2 * NORM_W;
	localparam int NSUM_W   = 2 * NORM_W + 2;
	localparam int NLEN_W   = NORM_W + 1;

	localparam int NRM_OUT_W = 18;

	typedef struct packed {
		logic                         hit;
		logic signed [31:0]           distance;
		logic signed [31:0]           point_x;
		logic signed [31:0]           point_y;
		logic signed [31:0]           point_z;
		logic signed [NRM_OUT_W-1:0]  normal_x;
		logic signed [NRM_OUT_W-1:0]  normal_y;
		logic signed [NRM_OUT_W-1:0]  normal_z;
	} res_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647) begin
			r = 32'sh7FFFFFFF;
		end else if (v < -64'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	// position of the highest set bit, 0 for an all-zero word
	function automatic logic [LEAD_W-1:0] lead_one(input logic [MAG_W-1:0] x);
		logic [LEAD_W-1:0] r;
		r = '0;
		for (int i = 0; i < MAG_W; i++) begin
			if (x[i]) begin
				r = LEAD_W'(i);
			end
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/rsi_ray_if.sv =====
// ----------------------------------------------------------------------------
// rsi_ray_if
// Ray item channel: origin and direction, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rsi_ray_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] origin_x;
	logic signed [31:0] origin_y;
	logic signed [31:0] origin_z;
	logic signed [31:0] dir_x;
	logic signed [31:0] dir_y;
	logic signed [31:0] dir_z;

	modport source (
		output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
		input  ready
	);
	modport sink (
		input  valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
		output ready
	);
endinterface

// ===== rtl/core/rsi_res_if.sv =====
// ----------------------------------------------------------------------------
// rsi_res_if
// Intersection result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rsi_res_if;
	logic               valid;
	logic               ready;
	logic               hit;
	logic signed [31:0] distance;
	logic signed [31:0] point_x;
	logic signed [31:0] point_y;
	logic signed [31:0] point_z;
	logic signed [17:0] normal_x;
	logic signed [17:0] normal_y;
	logic signed [17:0] normal_z;

	modport source (
		output valid, hit, distance, point_x, point_y, point_z,
		output normal_x, normal_y, normal_z,
		input  ready
	);
	modport sink (
		input  valid, hit, distance, point_x, point_y, point_z,
		input  normal_x, normal_y, normal_z,
		output ready
	);
endinterface

// ===== rtl/core/rsi_sqrt.sv =====
// ----------------------------------------------------------------------------
// rsi_sqrt
// Pipelined integer square root, one root bit per stage, floor result.
// A sideband word travels alongside each item.
// ----------------------------------------------------------------------------
module rsi_sqrt #(
	parameter int W   = 62,
	parameter int SBW = 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  logic [W-1:0]   x,
	input  logic [SBW-1:0] in_sb,
	output logic           out_valid,
	output logic [W/2-1:0] root,
	output logic [SBW-1:0] out_sb
);

	localparam int H  = W / 2;
	localparam int RW = H + 2;

	logic           v_s    [H];
	logic [RW-1:0]  rem_s  [H];
	logic [H-1:0]   root_s [H];
	logic [W-1:0]   x_s    [H];
	logic [SBW-1:0] sb_s   [H];

	for (genvar j = 0; j < H; j++) begin : g_stage
		logic           pv;
		logic [RW-1:0]  prem;
		logic [H-1:0]   proot;
		logic [W-1:0]   px;
		logic [SBW-1:0] psb;
		logic [RW-1:0]  cur;
		logic [RW-1:0]  trial;
		logic           ge;

		if (j == 0) begin : g_first
			assign pv    = in_valid;
			assign prem  = '0;
			assign proot = '0;
			assign px    = x;
			assign psb   = in_sb;
		end else begin : g_next
			assign pv    = v_s[j-1];
			assign prem  = rem_s[j-1];
			assign proot = root_s[j-1];
			assign px    = x_s[j-1];
			assign psb   = sb_s[j-1];
		end

		// bring down the next two radicand bits, try root*4+1
		assign cur   = {prem[RW-3:0], px[W-1 -: 2]};
		assign trial = {proot, 2'b01};
		assign ge    = cur >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j] <= 1'b0;
			end else if (en) begin
				v_s[j] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j]  <= ge ? cur - trial : cur;
				root_s[j] <= {proot[H-2:0], ge};
				x_s[j]    <= px << 2;
				sb_s[j]   <= psb;
			end
		end
	end

	assign out_valid = v_s[H-1];
	assign root      = root_s[H-1];
	assign out_sb    = sb_s[H-1];

endmodule

// ===== rtl/core/rsi_norm.sv =====
// ----------------------------------------------------------------------------
// rsi_norm
// Pipelined vector normalizer: align magnitudes, sum of squares, square root,
// then one quotient bit per stage for each lane.
// ----------------------------------------------------------------------------
module rsi_norm #(
	parameter int F   = 16,
	parameter int SBW = 1
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 en,
	input  logic                                 in_valid,
	input  logic signed [rsi_pkg::MAG_W-1:0]     v [3],
	input  logic [SBW-1:0]                       in_sb,
	output logic                                 out_valid,
	output logic signed [F+1:0]                  n [3],
	output logic [SBW-1:0]                       out_sb
);

	localparam int QW = F + 1;

	typedef struct packed {
		logic [2:0][rsi_pkg::NORM_W-1:0] sh;
		logic [2:0]                      neg;
		logic                            zero;
		logic [SBW-1:0]                  sb;
	} nsb_t;

	typedef struct packed {
		logic [2:0]     neg;
		logic           zero;
		logic [SBW-1:0] sb;
	} meta_t;

	// front end
	logic                            v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [rsi_pkg::MAG_W-1:0]       mag_s1 [3];
	logic [rsi_pkg::MAG_W-1:0]       mag_s2 [3];
	logic [2:0]                      neg_s1, neg_s2, neg_s3, neg_s4, neg_s5;
	logic [SBW-1:0]                  sb_s1, sb_s2, sb_s3, sb_s4, sb_s5;
	logic [rsi_pkg::LEAD_W-1:0]      lead_s2;
	logic                            zero_s2, zero_s3, zero_s4, zero_s5;
	logic [2:0][rsi_pkg::NORM_W-1:0] sh_s3, sh_s4, sh_s5;
	logic [rsi_pkg::NSQ_W-1:0]       sq_s4 [3];
	logic [rsi_pkg::NSUM_W-1:0]      sum_s5;

	logic [rsi_pkg::MAG_W-1:0]       mag_c [3];
	logic [rsi_pkg::MAG_W-1:0]       shw_c [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag_c[i] = v[i][rsi_pkg::MAG_W-1] ? rsi_pkg::MAG_W'(-v[i]) : v[i];
			if (lead_s2 > rsi_pkg::LEAD_W'(rsi_pkg::NORM_TOP)) begin
				shw_c[i] = mag_s2[i] >> (lead_s2 - rsi_pkg::LEAD_W'(rsi_pkg::NORM_TOP));
			end else begin
				shw_c[i] = mag_s2[i] << (rsi_pkg::LEAD_W'(rsi_pkg::NORM_TOP) - lead_s2);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				mag_s1[i] <= mag_c[i];
				neg_s1[i] <= v[i][rsi_pkg::MAG_W-1];
				mag_s2[i] <= mag_s1[i];
				sh_s3[i]  <= shw_c[i][rsi_pkg::NORM_W-1:0];
				sq_s4[i]  <= rsi_pkg::NSQ_W'(sh_s3[i]) * rsi_pkg::NSQ_W'(sh_s3[i]);
			end
			sb_s1   <= in_sb;
			lead_s2 <= rsi_pkg::lead_one(mag_s1[0] | mag_s1[1] | mag_s1[2]);
			zero_s2 <= (mag_s1[0] | mag_s1[1] | mag_s1[2]) == '0;
			neg_s2  <= neg_s1;
			sb_s2   <= sb_s1;
			zero_s3 <= zero_s2;
			neg_s3  <= neg_s2;
			sb_s3   <= sb_s2;
			sh_s4   <= sh_s3;
			zero_s4 <= zero_s3;
			neg_s4  <= neg_s3;
			sb_s4   <= sb_s3;
			sum_s5  <= rsi_pkg::NSUM_W'(sq_s4[0]) + rsi_pkg::NSUM_W'(sq_s4[1])
				+ rsi_pkg::NSUM_W'(sq_s4[2]);
			sh_s5   <= sh_s4;
			zero_s5 <= zero_s4;
			neg_s5  <= neg_s4;
			sb_s5   <= sb_s4;
		end
	end

	// length = floor(sqrt(sum of squares))
	nsb_t                        sq_in_sb, sq_out_sb;
	logic                        sq_valid;
	logic [rsi_pkg::NLEN_W-1:0]  sq_len;

	assign sq_in_sb = '{sh: sh_s5, neg: neg_s5, zero: zero_s5, sb: sb_s5};

	rsi_sqrt #(
		.W   (rsi_pkg::NSUM_W),
		.SBW ($bits(nsb_t))
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s5),
		.x         (sum_s5),
		.in_sb     (sq_in_sb),
		.out_valid (sq_valid),
		.root      (sq_len),
		.out_sb    (sq_out_sb)
	);

	// restoring division (mag << F) / len, one quotient bit per stage
	logic                       vd_s   [QW];
	logic [rsi_pkg::NLEN_W-1:0] len_s  [QW];
	logic [rsi_pkg::NLEN_W-1:0] rem_s  [QW][3];
	logic [QW-1:0]              quo_s  [QW][3];
	meta_t                      meta_s [QW];

	for (genvar k = 0; k < QW; k++) begin : g_div
		logic                       pv;
		logic [rsi_pkg::NLEN_W-1:0] plen;
		logic [QW-1:0]              pquo [3];
		meta_t                      pmeta;
		logic [rsi_pkg::NLEN_W:0]   cur [3];
		logic [2:0]                 ge;

		if (k == 0) begin : g_first
			assign pv    = sq_valid;
			assign plen  = sq_len;
			assign pmeta = '{neg: sq_out_sb.neg, zero: sq_out_sb.zero, sb: sq_out_sb.sb};
			always_comb begin
				for (int i = 0; i < 3; i++) begin
					pquo[i] = '0;
					cur[i]  = (rsi_pkg::NLEN_W + 1)'(sq_out_sb.sh[i]);
				end
			end
		end else begin : g_next
			assign pv    = vd_s[k-1];
			assign plen  = len_s[k-1];
			assign pmeta = meta_s[k-1];
			always_comb begin
				for (int i = 0; i < 3; i++) begin
					pquo[i] = quo_s[k-1][i];
					cur[i]  = {rem_s[k-1][i], 1'b0};
				end
			end
		end

		always_comb begin
			for (int i = 0; i < 3; i++) begin
				ge[i] = cur[i] >= {1'b0, plen};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vd_s[k] <= 1'b0;
			end else if (en) begin
				vd_s[k] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				len_s[k]  <= plen;
				meta_s[k] <= pmeta;
				for (int i = 0; i < 3; i++) begin
					rem_s[k][i] <= ge[i] ? rsi_pkg::NLEN_W'(cur[i] - {1'b0, plen})
						: cur[i][rsi_pkg::NLEN_W-1:0];
					quo_s[k][i] <= pquo[i] | (QW'(ge[i]) << (F - k));
				end
			end
		end
	end

	// sign back on; an all-zero vector normalizes to zero
	logic                vo_sf;
	logic signed [F+1:0] n_sf [3];
	logic [SBW-1:0]      sb_sf;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vo_sf <= 1'b0;
		end else if (en) begin
			vo_sf <= vd_s[QW-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sb_sf <= meta_s[QW-1].sb;
			for (int i = 0; i < 3; i++) begin
				if (meta_s[QW-1].zero) begin
					n_sf[i] <= '0;
				end else if (meta_s[QW-1].neg[i]) begin
					n_sf[i] <= -$signed({1'b0, quo_s[QW-1][i]});
				end else begin
					n_sf[i] <= $signed({1'b0, quo_s[QW-1][i]});
				end
			end
		end
	end

	assign out_valid = vo_sf;
	assign out_sb    = sb_sf;
	assign n         = n_sf;

endmodule

// ===== rtl/core/ray_sphere_intersect_core.sv =====
// ----------------------------------------------------------------------------
// ray_sphere_intersect_core
// Ray/sphere intersection in signed fixed point: distance, hit point and
// unit surface normal for one ray per cycle.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake        | contents
//  ray      | in  | valid/ready      | origin_x/y/z, dir_x/y/z
//  res      | out | valid/ready      | hit, distance, point_x/y/z, normal_x/y/z
//  cfg      | in  | cfg_we, no wait  | cfg_idx, cfg_wdata (center x/y/z, radius)
//
//  One ray per cycle sustained while the output buffer is not full. It uses
//  two normalizers (31-stage square root plus one quotient bit per stage
//  each), a 31-stage square root for the discriminant and arithmetic stages.
//  All stages advance together; a two-entry output buffer keeps the pipe
//  moving while one result waits. When it is full the whole pipe holds.
//  Reset clears valid bits and loads center 0 and radius 1.0.
// ----------------------------------------------------------------------------
module ray_sphere_intersect_core #(
	parameter int FRAC_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	rsi_ray_if.sink                         ray,
	rsi_res_if.source                       res,
	input  logic                            cfg_we,
	input  logic [rsi_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [rsi_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

	localparam int F   = FRAC_BITS;
	localparam int NW  = F + 2;
	localparam int DW  = 33;
	localparam int PDW = DW + NW;
	localparam int ACW = PDW + 2;
	localparam int BW  = ACW - F;
	localparam int PBW = BW + NW;
	localparam int FBW = PBW - F;
	localparam int PPW = FBW + 1;
	localparam int PNW = NW + 32;
	localparam int XW  = (NW > rsi_pkg::NRM_OUT_W) ? NW : rsi_pkg::NRM_OUT_W;

	localparam logic signed [31:0] MISS_DIST = -(32'sd1 << F);

	typedef struct packed {
		logic [2:0][31:0] o;
		logic [2:0][DW-1:0] dst;
	} sb1_t;

	typedef struct packed {
		logic               hit;
		logic [BW-1:0]      b;
		logic [2:0][31:0]   o;
		logic [2:0][NW-1:0] n;
	} sb2_t;

	typedef struct packed {
		logic             hit;
		logic [31:0]      dlen;
		logic [2:0][31:0] p;
	} sb3_t;

	// configuration
	logic signed [31:0] ctr_q [3];
	logic [30:0]        radius_q;
	logic [61:0]        r2_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_q[0] <= '0;
			ctr_q[1] <= '0;
			ctr_q[2] <= '0;
			radius_q <= 31'd65536;
			r2_q     <= 62'h1_0000_0000;
		end else begin
			r2_q <= 62'(radius_q) * 62'(radius_q);
			if (cfg_we) begin
				case (rsi_pkg::cfg_reg_t'(cfg_idx))
					rsi_pkg::CFG_CENTER_X: ctr_q[0] <= cfg_wdata;
					rsi_pkg::CFG_CENTER_Y: ctr_q[1] <= cfg_wdata;
					rsi_pkg::CFG_CENTER_Z: ctr_q[2] <= cfg_wdata;
					rsi_pkg::CFG_RADIUS:   radius_q <= cfg_wdata[30:0];
					default: ;
				endcase
			end
		end
	end

	// pipeline advance: stop only when the output buffer is full
	logic       en;
	logic [1:0] cnt_q;

	assign en        = cnt_q != 2'd2;
	assign ray.ready = en;

	// direction normalizer
	logic signed [DW-1:0] dir_ext [3];
	logic signed [31:0]   org [3];
	sb1_t                 sb1_in, n1_sb;
	logic                 n1_valid;
	logic signed [NW-1:0] n1 [3];

	assign org[0] = ray.origin_x;
	assign org[1] = ray.origin_y;
	assign org[2] = ray.origin_z;
	assign dir_ext[0] = DW'(ray.dir_x);
	assign dir_ext[1] = DW'(ray.dir_y);
	assign dir_ext[2] = DW'(ray.dir_z);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sb1_in.o[i]   = org[i];
			sb1_in.dst[i] = DW'(org[i]) - DW'(ctr_q[i]);
		end
	end

	rsi_norm #(
		.F   (F),
		.SBW ($bits(sb1_t))
	) u_norm_dir (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (ray.valid),
		.v         (dir_ext),
		.in_sb     (sb1_in),
		.out_valid (n1_valid),
		.n         (n1),
		.out_sb    (n1_sb)
	);

	// b = (o-c).n, perpendicular offset, discriminant
	logic                 v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic signed [PDW-1:0] pd_s1 [3];
	logic signed [31:0]   o_s1 [3], o_s2 [3], o_s3 [3], o_s4 [3], o_s5 [3];
	logic signed [31:0]   o_s6 [3], o_s7 [3], o_s8 [3];
	logic signed [DW-1:0] dst_s1 [3], dst_s2 [3], dst_s3 [3];
	logic signed [NW-1:0] n_s1 [3], n_s2 [3], n_s3 [3], n_s4 [3], n_s5 [3];
	logic signed [NW-1:0] n_s6 [3], n_s7 [3], n_s8 [3];
	logic signed [BW-1:0] b_s2, b_s3, b_s4, b_s5, b_s6, b_s7, b_s8;
	logic signed [PBW-1:0] pb_s3 [3];
	logic signed [PPW-1:0] perp_s4 [3];
	logic [30:0]          pm_s5 [3];
	logic                 small_s5, small_s6, small_s7;
	logic [61:0]          sq_s6 [3];
	logic [63:0]          psum_s7;
	logic                 hit_s8;
	logic [61:0]          disc_s8;

	logic signed [ACW-1:0] acc_c;
	logic [PPW-1:0]        pmag_c [3];
	logic                  big_c;

	always_comb begin
		acc_c = ACW'(pd_s1[0]) + ACW'(pd_s1[1]) + ACW'(pd_s1[2]);
		big_c = 1'b0;
		for (int i = 0; i < 3; i++) begin
			pmag_c[i] = perp_s4[i][PPW-1] ? PPW'(-perp_s4[i]) : perp_s4[i];
			big_c     = big_c | (|pmag_c[i][PPW-1:31]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s1 <= n1_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				pd_s1[i]   <= $signed(n1_sb.dst[i]) * n1[i];
				o_s1[i]    <= n1_sb.o[i];
				dst_s1[i]  <= n1_sb.dst[i];
				n_s1[i]    <= n1[i];
				o_s2[i]    <= o_s1[i];
				dst_s2[i]  <= dst_s1[i];
				n_s2[i]    <= n_s1[i];
				pb_s3[i]   <= b_s2 * n_s2[i];
				o_s3[i]    <= o_s2[i];
				dst_s3[i]  <= dst_s2[i];
				n_s3[i]    <= n_s2[i];
				perp_s4[i] <= PPW'(dst_s3[i]) - PPW'(pb_s3[i] >>> F);
				o_s4[i]    <= o_s3[i];
				n_s4[i]    <= n_s3[i];
				pm_s5[i]   <= pmag_c[i][30:0];
				o_s5[i]    <= o_s4[i];
				n_s5[i]    <= n_s4[i];
				sq_s6[i]   <= 62'(pm_s5[i]) * 62'(pm_s5[i]);
				o_s6[i]    <= o_s5[i];
				n_s6[i]    <= n_s5[i];
				o_s7[i]    <= o_s6[i];
				n_s7[i]    <= n_s6[i];
				o_s8[i]    <= o_s7[i];
				n_s8[i]    <= n_s7[i];
			end
			b_s2     <= BW'(acc_c >>> F);
			b_s3     <= b_s2;
			b_s4     <= b_s3;
			b_s5     <= b_s4;
			small_s5 <= !big_c;
			b_s6     <= b_s5;
			small_s6 <= small_s5;
			psum_s7  <= 64'(sq_s6[0]) + 64'(sq_s6[1]) + 64'(sq_s6[2]);
			small_s7 <= small_s6;
			b_s7     <= b_s6;
			hit_s8   <= small_s7 && (psum_s7 < 64'(r2_q));
			disc_s8  <= r2_q - psum_s7[61:0];
			b_s8     <= b_s7;
		end
	end

	// sqrt(disc)
	sb2_t        sb2_in, q2_sb;
	logic        q2_valid;
	logic [30:0] q2_root;

	always_comb begin
		sb2_in.hit = hit_s8;
		sb2_in.b   = b_s8;
		for (int i = 0; i < 3; i++) begin
			sb2_in.o[i] = o_s8[i];
			sb2_in.n[i] = n_s8[i];
		end
	end

	rsi_sqrt #(
		.W   (62),
		.SBW ($bits(sb2_t))
	) u_sqrt_disc (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s8),
		.x         (disc_s8),
		.in_sb     (sb2_in),
		.out_valid (q2_valid),
		.root      (q2_root),
		.out_sb    (q2_sb)
	);

	// distance and hit point
	logic                  v_s9, v_s10, v_s11;
	logic                  hit_s9, hit_s10, hit_s11;
	logic signed [31:0]    dist_s9, dist_s10, dist_s11;
	logic signed [31:0]    o_s9 [3], o_s10 [3];
	logic signed [NW-1:0]  n_s9 [3];
	logic signed [PNW-1:0] pn_s10 [3];
	logic signed [31:0]    p_s11 [3];
	logic signed [63:0]    dsum_c;
	logic signed [31:0]    pt_c [3];

	always_comb begin
		dsum_c = 64'sd0 - 64'($signed(q2_sb.b)) - $signed({33'd0, q2_root});
		for (int i = 0; i < 3; i++) begin
			pt_c[i] = rsi_pkg::sat32(64'(o_s10[i]) + 64'(pn_s10[i] >>> F));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
		end else if (en) begin
			v_s9  <= q2_valid;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s9   <= q2_sb.hit;
			dist_s9  <= q2_sb.hit ? rsi_pkg::sat32(dsum_c) : MISS_DIST;
			hit_s10  <= hit_s9;
			dist_s10 <= dist_s9;
			hit_s11  <= hit_s10;
			dist_s11 <= dist_s10;
			for (int i = 0; i < 3; i++) begin
				o_s9[i]   <= q2_sb.o[i];
				n_s9[i]   <= q2_sb.n[i];
				pn_s10[i] <= n_s9[i] * dist_s9;
				o_s10[i]  <= o_s9[i];
				p_s11[i]  <= pt_c[i];
			end
		end
	end

	// surface normal
	logic signed [DW-1:0] pc_c [3];
	sb3_t                 sb3_in, n2_sb;
	logic                 n2_valid;
	logic signed [NW-1:0] n2 [3];

	always_comb begin
		sb3_in.hit  = hit_s11;
		sb3_in.dlen = dist_s11;
		for (int i = 0; i < 3; i++) begin
			pc_c[i]     = DW'(p_s11[i]) - DW'(ctr_q[i]);
			sb3_in.p[i] = p_s11[i];
		end
	end

	rsi_norm #(
		.F   (F),
		.SBW ($bits(sb3_t))
	) u_norm_nrm (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s11),
		.v         (pc_c),
		.in_sb     (sb3_in),
		.out_valid (n2_valid),
		.n         (n2),
		.out_sb    (n2_sb)
	);

	// output buffer, two entries
	rsi_pkg::res_t        fifo_q [2];
	rsi_pkg::res_t        new_res;
	rsi_pkg::res_t        head;
	logic                 wr_q, rd_q;
	logic                 push, pop;
	logic signed [XW-1:0] nx_c [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			nx_c[i] = XW'(n2[i]);
		end
		new_res.hit      = n2_sb.hit;
		new_res.distance = n2_sb.dlen;
		new_res.point_x  = n2_sb.p[0];
		new_res.point_y  = n2_sb.p[1];
		new_res.point_z  = n2_sb.p[2];
		new_res.normal_x = nx_c[0][rsi_pkg::NRM_OUT_W-1:0];
		new_res.normal_y = nx_c[1][rsi_pkg::NRM_OUT_W-1:0];
		new_res.normal_z = nx_c[2][rsi_pkg::NRM_OUT_W-1:0];
	end

	assign push = n2_valid && en;
	assign pop  = res.valid && res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_q] <= new_res;
		end
	end

	assign head         = fifo_q[rd_q];
	assign res.valid    = cnt_q != 2'd0;
	assign res.hit      = head.hit;
	assign res.distance = head.distance;
	assign res.point_x  = head.point_x;
	assign res.point_y  = head.point_y;
	assign res.point_z  = head.point_z;
	assign res.normal_x = head.normal_x;
	assign res.normal_y = head.normal_y;
	assign res.normal_z = head.normal_z;

	// checks
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("output buffer count out of range");

	a_hold_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!en && n2_valid) |=> n2_valid)
		else $error("item lost at pipe end during hold");

	a_hold_full: assert property (@(posedge clk) disable iff (!arst_n)
		!en |-> (res.valid && wr_q == rd_q))
		else $error("pipe held without a full output buffer");

endmodule
